>>> hdl/fsuc_pkg.sv
// shared types, codes and crc function for the flash slot upload checker
package fsuc_pkg;

  localparam int FUNC_W      = 3;
  localparam int SLOT_W      = 8;
  localparam int CRC_W       = 32;
  localparam int OFF_W       = 24;
  localparam int LEN_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int STAT_W      = 4;
  localparam int ACT_W       = 2;
  localparam int ADDR_W      = 24;
  localparam int PIX_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FN_BEGIN  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CHUNK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DATA   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FINISH = 3'd3;
  localparam logic [FUNC_W-1:0] FN_ABORT  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK          = 4'd0;
  localparam logic [STAT_W-1:0] ST_BUSY        = 4'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SLOT    = 4'd2;
  localparam logic [STAT_W-1:0] ST_NOT_WRITING = 4'd3;
  localparam logic [STAT_W-1:0] ST_OFFSET      = 4'd4;
  localparam logic [STAT_W-1:0] ST_OVERRUN     = 4'd5;
  localparam logic [STAT_W-1:0] ST_SHORT       = 4'd6;
  localparam logic [STAT_W-1:0] ST_CRC         = 4'd7;
  localparam logic [STAT_W-1:0] ST_NO_CHUNK    = 4'd8;

  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ERASE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PROGRAM = 2'd2;
  localparam logic [ACT_W-1:0] ACT_HEADER  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BUNDLE_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_OFFSET = 2'd3;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic [ADDR_W-1:0] base;
    logic [CRC_W-1:0]  ecrc;
    logic [OFF_W-1:0]  coff;
    logic [LEN_W-1:0]  clen;
    logic [BYTE_W-1:0] dbyte;
  } fsuc_item_t;

  typedef struct packed {
    logic              accepted;
    logic [STAT_W-1:0] status;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] pbyte;
  } fsuc_result_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/fsuc_front.sv
// front end: decodes an item, checks its slot and computes the slot base
module fsuc_front (
  input  logic [fsuc_pkg::FUNC_W-1:0] in_func,
  input  logic [fsuc_pkg::SLOT_W-1:0] in_slot,
  input  logic [fsuc_pkg::CRC_W-1:0]  in_expected_crc,
  input  logic [fsuc_pkg::OFF_W-1:0]  in_chunk_offset,
  input  logic [fsuc_pkg::LEN_W-1:0]  in_chunk_length,
  input  logic [fsuc_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [fsuc_pkg::ADDR_W-1:0] slot_bytes,
  input  logic [fsuc_pkg::SLOT_W-1:0] slot_count,
  output fsuc_pkg::fsuc_item_t        item
);
  import fsuc_pkg::*;

  logic [SLOT_W+ADDR_W-1:0] base_full;

  assign base_full = in_slot * slot_bytes;

  always_comb begin
    item.func    = in_func;
    item.slot    = in_slot;
    item.slot_ok = (in_slot < slot_count);
    item.base    = base_full[ADDR_W-1:0];
    item.ecrc    = in_expected_crc;
    item.coff    = in_chunk_offset;
    item.clen    = in_chunk_length;
    item.dbyte   = in_data_byte;
  end

endmodule

>>> hdl/fsuc_queue.sv
// short register queue between front and back
module fsuc_queue #(
  parameter int DEPTH = fsuc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fsuc_pkg::fsuc_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output fsuc_pkg::fsuc_item_t head_item
);
  import fsuc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fsuc_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hdl/fsuc_back.sv
// back end: session state, crc, flash request and output register
module fsuc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  fsuc_pkg::fsuc_item_t        item,
  output logic                        item_take,
  input  logic [fsuc_pkg::OFF_W-1:0]  bundle_bytes,
  input  logic [fsuc_pkg::ADDR_W-1:0] slot_bytes,
  input  logic [fsuc_pkg::PIX_W-1:0]  pixel_offset,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fsuc_pkg::fsuc_result_t      res
);
  import fsuc_pkg::*;

  logic              open_r, open_nxt;
  logic [SLOT_W-1:0] tslot_r, tslot_nxt;
  logic [OFF_W-1:0]  bw_r, bw_nxt;
  logic [CRC_W-1:0]  goal_r, goal_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0] tbase_r, tbase_nxt;
  logic [ADDR_W-1:0] tpix_r, tpix_nxt;
  logic              out_valid_r;
  fsuc_result_t      out_r, result;

  logic [SLOT_W+ADDR_W-1:0] prod;
  logic [OFF_W:0]           chunk_end;

  assign item_take = item_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  assign prod      = tslot_r * slot_bytes;
  assign chunk_end = {1'b0, bw_r} + {{(OFF_W+1-LEN_W){1'b0}}, item.clen};

  always_comb begin
    open_nxt  = open_r;
    tslot_nxt = tslot_r;
    bw_nxt    = bw_r;
    goal_nxt  = goal_r;
    crc_nxt   = crc_r;
    rem_nxt   = rem_r;
    tbase_nxt = prod[ADDR_W-1:0];
    tpix_nxt  = prod[ADDR_W-1:0] + {{(ADDR_W-PIX_W){1'b0}}, pixel_offset};
    result    = '0;
    if (item_take) begin
      case (item.func)
        FN_BEGIN: begin
          if (open_r) begin
            result.status = ST_BUSY;
          end else if (!item.slot_ok) begin
            result.status = ST_BAD_SLOT;
          end else begin
            result.accepted = 1'b1;
            result.action   = ACT_ERASE;
            result.addr     = item.base;
            open_nxt        = 1'b1;
            tslot_nxt       = item.slot;
            bw_nxt          = '0;
            goal_nxt        = item.ecrc;
            crc_nxt         = CRC_INIT;
            rem_nxt         = '0;
            tbase_nxt       = item.base;
            tpix_nxt        = item.base + {{(ADDR_W-PIX_W){1'b0}}, pixel_offset};
          end
        end
        FN_CHUNK: begin
          if (!open_r) begin
            result.status = ST_NOT_WRITING;
          end else if (item.coff != bw_r) begin
            result.status = ST_OFFSET;
          end else if (chunk_end > {1'b0, bundle_bytes}) begin
            result.status = ST_OVERRUN;
          end else begin
            result.accepted = 1'b1;
            rem_nxt         = item.clen;
          end
        end
        FN_DATA: begin
          if (!open_r) begin
            result.status = ST_NOT_WRITING;
          end else if (rem_r == '0) begin
            result.status = ST_NO_CHUNK;
          end else begin
            result.accepted = 1'b1;
            result.action   = ACT_PROGRAM;
            result.addr     = tpix_r + bw_r;
            result.pbyte    = item.dbyte;
            crc_nxt         = crc_byte(crc_r, item.dbyte);
            bw_nxt          = bw_r + 1'b1;
            rem_nxt         = rem_r - 1'b1;
          end
        end
        FN_FINISH: begin
          if (!open_r) begin
            result.status = ST_NOT_WRITING;
          end else begin
            open_nxt = 1'b0;
            rem_nxt  = '0;
            if (bw_r != bundle_bytes) begin
              result.status = ST_SHORT;
            end else if (~crc_r != goal_r) begin
              result.status = ST_CRC;
            end else begin
              result.accepted = 1'b1;
              result.action   = ACT_HEADER;
              result.addr     = tbase_r;
            end
          end
        end
        FN_ABORT: begin
          if (!open_r) begin
            result.status = ST_NOT_WRITING;
          end else begin
            result.accepted = 1'b1;
            open_nxt        = 1'b0;
            rem_nxt         = '0;
          end
        end
        FN_ERASE: begin
          if (open_r) begin
            result.status = ST_BUSY;
          end else if (!item.slot_ok) begin
            result.status = ST_BAD_SLOT;
          end else begin
            result.accepted = 1'b1;
            result.action   = ACT_ERASE;
            result.addr     = item.base;
          end
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      tslot_r     <= '0;
      bw_r        <= '0;
      goal_r      <= '0;
      crc_r       <= CRC_INIT;
      rem_r       <= '0;
      tbase_r     <= '0;
      tpix_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      open_r  <= open_nxt;
      tslot_r <= tslot_nxt;
      bw_r    <= bw_nxt;
      goal_r  <= goal_nxt;
      crc_r   <= crc_nxt;
      rem_r   <= rem_nxt;
      tbase_r <= tbase_nxt;
      tpix_r  <= tpix_nxt;
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_r <= result;
    end
  end

endmodule

>>> hdl/flash_slot_upload_checker_top.sv
// top level of the flash slot upload checker
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   func, slot, expected_crc, chunk offset/length, byte
// out      output     out_valid / out_ready accepted, status, flash action/address, byte
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// one item per cycle unless out_ready stalls; each item goes via the queue and output register
// the back end resolves an item combinationally, including a byte-wide crc update
// reset is synchronous, active low; all but data registers reset to zero, crc to all ones
// in_ready drops only when the queue is full; the output register takes a new
// result in the same cycle the previous one is taken
module flash_slot_upload_checker_top #(
  parameter int QUEUE_DEPTH = fsuc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fsuc_pkg::FUNC_W-1:0]     in_func,
  input  logic [fsuc_pkg::SLOT_W-1:0]     in_slot,
  input  logic [fsuc_pkg::CRC_W-1:0]      in_expected_crc,
  input  logic [fsuc_pkg::OFF_W-1:0]      in_chunk_offset,
  input  logic [fsuc_pkg::LEN_W-1:0]      in_chunk_length,
  input  logic [fsuc_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic [fsuc_pkg::STAT_W-1:0]     out_status,
  output logic [fsuc_pkg::ACT_W-1:0]      out_flash_action,
  output logic [fsuc_pkg::ADDR_W-1:0]     out_flash_address,
  output logic [fsuc_pkg::BYTE_W-1:0]     out_program_byte,
  input  logic                            cfg_we,
  input  logic [fsuc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsuc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fsuc_pkg::*;

  logic [OFF_W-1:0]  bundle_bytes_r;
  logic [ADDR_W-1:0] slot_bytes_r;
  logic [SLOT_W-1:0] slot_count_r;
  logic [PIX_W-1:0]  pixel_offset_r;

  fsuc_item_t   front_item;
  fsuc_item_t   head_item;
  fsuc_result_t res;
  logic         q_full;
  logic         q_push;
  logic         q_pop;
  logic         q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bundle_bytes_r <= '0;
      slot_bytes_r   <= '0;
      slot_count_r   <= '0;
      pixel_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUNDLE_BYTES: bundle_bytes_r <= cfg_wdata[OFF_W-1:0];
        REG_SLOT_BYTES:   slot_bytes_r   <= cfg_wdata[ADDR_W-1:0];
        REG_SLOT_COUNT:   slot_count_r   <= cfg_wdata[SLOT_W-1:0];
        REG_PIXEL_OFFSET: pixel_offset_r <= cfg_wdata[PIX_W-1:0];
        default: begin
          bundle_bytes_r <= bundle_bytes_r;
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  fsuc_front u_front (
    .in_func         (in_func),
    .in_slot         (in_slot),
    .in_expected_crc (in_expected_crc),
    .in_chunk_offset (in_chunk_offset),
    .in_chunk_length (in_chunk_length),
    .in_data_byte    (in_data_byte),
    .slot_bytes      (slot_bytes_r),
    .slot_count      (slot_count_r),
    .item            (front_item)
  );

  fsuc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  fsuc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (q_valid),
    .item         (head_item),
    .item_take    (q_pop),
    .bundle_bytes (bundle_bytes_r),
    .slot_bytes   (slot_bytes_r),
    .pixel_offset (pixel_offset_r),
    .res_valid    (out_valid),
    .res_ready    (out_ready),
    .res          (res)
  );

  assign out_accepted      = res.accepted;
  assign out_status        = res.status;
  assign out_flash_action  = res.action;
  assign out_flash_address = res.addr;
  assign out_program_byte  = res.pbyte;

endmodule

>>> sim/flash_slot_upload_checker_top_tb.sv
// self-checking testbench for the flash slot upload checker: directed and random upload sessions
`timescale 1ns / 1ps

module flash_slot_upload_checker_top_tb;
  import fsuc_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
    logic [CRC_W-1:0]  expected_crc;
    logic [OFF_W-1:0]  chunk_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic [BYTE_W-1:0] data_byte;
  } upload_cmd_t;

  typedef struct packed {
    logic              accepted;
    logic [STAT_W-1:0] status;
    logic [ACT_W-1:0]  flash_action;
    logic [ADDR_W-1:0] flash_address;
    logic [BYTE_W-1:0] program_byte;
  } upload_resp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func;
  logic [SLOT_W-1:0]     in_slot;
  logic [CRC_W-1:0]      in_expected_crc;
  logic [OFF_W-1:0]      in_chunk_offset;
  logic [LEN_W-1:0]      in_chunk_length;
  logic [BYTE_W-1:0]     in_data_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_accepted;
  logic [STAT_W-1:0]     out_status;
  logic [ACT_W-1:0]      out_flash_action;
  logic [ADDR_W-1:0]     out_flash_address;
  logic [BYTE_W-1:0]     out_program_byte;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  flash_slot_upload_checker_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_slot           (in_slot),
    .in_expected_crc   (in_expected_crc),
    .in_chunk_offset   (in_chunk_offset),
    .in_chunk_length   (in_chunk_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_status        (out_status),
    .out_flash_action  (out_flash_action),
    .out_flash_address (out_flash_address),
    .out_program_byte  (out_program_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  upload_cmd_t  cmd_backlog[$];
  upload_resp_t resp_due[$];
  upload_cmd_t  cur_cmd;
  logic         in_took = 1'b0;
  logic         idle_en = 1'b1;
  int           in_gap = 0;
  int           out_hold = 0;
  int           queued = 0;
  int           quiet_cycles = 0;
  int           fails = 0;
  int           n_items = 0;
  int           n_programmed = 0;
  int           n_commits = 0;
  int           n_refused = 0;
  int           n_settings = 0;
  logic [23:0]  plan_bundle;
  logic [7:0]   plan_slots;

  // predictor state and register copy
  logic        sess_open;
  logic [7:0]  sess_slot;
  logic [23:0] sess_bytes;
  logic [31:0] sess_crc_goal;
  logic [31:0] sess_crc;
  logic [15:0] chunk_left;
  logic [23:0] reg_bundle;
  logic [23:0] reg_slot_bytes;
  logic [7:0]  reg_slot_count;
  logic [15:0] reg_pix_off;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] crc_fold(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ ((c[0] ^ b[k]) ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic logic [23:0] slot_base(logic [7:0] s);
    logic [31:0] prod;
    prod = {24'd0, s} * {8'd0, reg_slot_bytes};
    return prod[23:0];
  endfunction

  function automatic upload_resp_t judge_upload_item(upload_cmd_t c);
    upload_resp_t r;
    r = '0;
    r.status = ST_OK;
    r.flash_action = ACT_NONE;
    case (c.func)
      FN_BEGIN: begin
        if (sess_open) begin
          r.status = ST_BUSY;
        end else if (c.slot >= reg_slot_count) begin
          r.status = ST_BAD_SLOT;
        end else begin
          sess_open = 1'b1;
          sess_slot = c.slot;
          sess_bytes = '0;
          sess_crc_goal = c.expected_crc;
          sess_crc = CRC_INIT;
          chunk_left = '0;
          r.accepted = 1'b1;
          r.flash_action = ACT_ERASE;
          r.flash_address = slot_base(c.slot);
        end
      end
      FN_CHUNK: begin
        if (!sess_open) begin
          r.status = ST_NOT_WRITING;
        end else if (c.chunk_offset != sess_bytes) begin
          r.status = ST_OFFSET;
        end else if (({8'd0, sess_bytes} + {16'd0, c.chunk_length}) > {8'd0, reg_bundle}) begin
          r.status = ST_OVERRUN;
        end else begin
          chunk_left = c.chunk_length;
          r.accepted = 1'b1;
        end
      end
      FN_DATA: begin
        if (!sess_open) begin
          r.status = ST_NOT_WRITING;
        end else if (chunk_left == 16'd0) begin
          r.status = ST_NO_CHUNK;
        end else begin
          r.accepted = 1'b1;
          r.flash_action = ACT_PROGRAM;
          r.flash_address = slot_base(sess_slot) + {8'd0, reg_pix_off} + sess_bytes;
          r.program_byte = c.data_byte;
          sess_crc = crc_fold(sess_crc, c.data_byte);
          sess_bytes = sess_bytes + 24'd1;
          chunk_left = chunk_left - 16'd1;
        end
      end
      FN_FINISH: begin
        if (!sess_open) begin
          r.status = ST_NOT_WRITING;
        end else begin
          sess_open = 1'b0;
          chunk_left = '0;
          if (sess_bytes != reg_bundle) begin
            r.status = ST_SHORT;
          end else if (~sess_crc != sess_crc_goal) begin
            r.status = ST_CRC;
          end else begin
            r.accepted = 1'b1;
            r.flash_action = ACT_HEADER;
            r.flash_address = slot_base(sess_slot);
          end
        end
      end
      FN_ABORT: begin
        if (!sess_open) begin
          r.status = ST_NOT_WRITING;
        end else begin
          sess_open = 1'b0;
          chunk_left = '0;
          r.accepted = 1'b1;
        end
      end
      FN_ERASE: begin
        if (sess_open) begin
          r.status = ST_BUSY;
        end else if (c.slot >= reg_slot_count) begin
          r.status = ST_BAD_SLOT;
        end else begin
          r.accepted = 1'b1;
          r.flash_action = ACT_ERASE;
          r.flash_address = slot_base(c.slot);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic upload_cmd_t rnd_cmd();
    upload_cmd_t c;
    c.func = 3'($urandom_range(0, 7));
    c.slot = 8'($urandom);
    c.expected_crc = $urandom;
    c.chunk_offset = 24'($urandom);
    c.chunk_length = 16'($urandom);
    c.data_byte = 8'($urandom);
    return c;
  endfunction

  task automatic enqueue(upload_cmd_t c);
    cmd_backlog.push_back(c);
    queued++;
  endtask

  // fields the func does not use stay random
  task automatic post(logic [FUNC_W-1:0] f, logic [31:0] a, logic [31:0] b);
    upload_cmd_t c;
    c = rnd_cmd();
    c.func = f;
    case (f)
      FN_BEGIN: begin
        c.slot = a[7:0];
        c.expected_crc = b;
      end
      FN_ERASE: begin
        c.slot = a[7:0];
      end
      FN_CHUNK: begin
        c.chunk_offset = a[23:0];
        c.chunk_length = b[15:0];
      end
      FN_DATA: begin
        c.data_byte = a[7:0];
      end
      default: begin
      end
    endcase
    enqueue(c);
  endtask

  function automatic logic [31:0] pick_slot();
    if (plan_slots != 8'd0 && $urandom_range(0, 5) != 0)
      return $urandom_range(0, {24'd0, plan_slots} - 1);
    return $urandom_range(0, 255);
  endfunction

  // one upload with random content, mostly well formed
  task automatic queue_session();
    int          n;
    int          done;
    int          len;
    int          sent;
    logic [31:0] run;
    logic [7:0]  payload[$];
    if (plan_bundle > 24'd40) n = $urandom_range(0, 24);
    else n = int'(plan_bundle);
    for (int i = 0; i < n; i++) payload.push_back(8'($urandom));
    run = CRC_INIT;
    foreach (payload[i]) run = crc_fold(run, payload[i]);
    post(FN_BEGIN, pick_slot(), ($urandom_range(0, 5) == 0) ? $urandom : ~run);
    done = 0;
    while (done < n) begin
      case ($urandom_range(0, 19))
        0: enqueue(rnd_cmd());
        1: post(FN_CHUNK, 32'(done + $urandom_range(1, 3)), 32'($urandom_range(1, 4)));
        2: post(FN_CHUNK, 32'(done), 32'(n - done + 1 + $urandom_range(0, 15)));
        3: post(FN_DATA, $urandom, 32'd0);
        4: post(FN_CHUNK, 32'(done), 32'd0);
        5: begin
          if ($urandom_range(0, 3) == 0) post(FN_FINISH, 32'd0, 32'd0);
        end
        default: begin
          len = $urandom_range(1, (n - done < 12) ? n - done : 12);
          post(FN_CHUNK, 32'(done), 32'(len));
          sent = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
          for (int k = 0; k < sent; k++) post(FN_DATA, 32'(payload[done + k]), 32'd0);
          done += sent;
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: post(FN_ABORT, 32'd0, 32'd0);
      1: begin
        post(FN_FINISH, 32'd0, 32'd0);
        post(FN_FINISH, 32'd0, 32'd0);
      end
      default: post(FN_FINISH, 32'd0, 32'd0);
    endcase
  endtask

  task automatic write_regs(logic [23:0] bundle, logic [23:0] sbytes, logic [7:0] count,
                            logic [15:0] poff);
    plan_bundle = bundle;
    plan_slots = count;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_BUNDLE_BYTES;
    cfg_wdata <= bundle;
    @(negedge clk);
    cfg_index <= REG_SLOT_BYTES;
    cfg_wdata <= sbytes;
    @(negedge clk);
    cfg_index <= REG_SLOT_COUNT;
    cfg_wdata <= {16'd0, count};
    @(negedge clk);
    cfg_index <= REG_PIXEL_OFFSET;
    cfg_wdata <= {8'd0, poff};
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    @(posedge clk);
    while (cmd_backlog.size() != 0 || in_valid || resp_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0 && idle_en && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        cur_cmd = cmd_backlog.pop_front();
        in_func <= cur_cmd.func;
        in_slot <= cur_cmd.slot;
        in_expected_crc <= cur_cmd.expected_crc;
        in_chunk_offset <= cur_cmd.chunk_offset;
        in_chunk_length <= cur_cmd.chunk_length;
        in_data_byte <= cur_cmd.data_byte;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (!idle_en) begin
      out_ready <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_hold = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: checks results, predicts accepted items, tracks register writes
  always @(posedge clk) begin : monitor
    upload_cmd_t  seen;
    upload_resp_t want;
    upload_resp_t got;
    logic         bad;
    if (!rst_n) begin
      sess_open = 1'b0;
      sess_slot = '0;
      sess_bytes = '0;
      sess_crc_goal = '0;
      sess_crc = CRC_INIT;
      chunk_left = '0;
      reg_bundle = '0;
      reg_slot_bytes = '0;
      reg_slot_count = '0;
      reg_pix_off = '0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_accepted, out_status, out_flash_action, out_flash_address,
               out_program_byte};
        if (resp_due.size() == 0) begin
          $error("result with no item outstanding: %h", got);
          fails++;
        end else begin
          want = resp_due.pop_front();
          bad = 1'b0;
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            bad = 1'b1;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            bad = 1'b1;
          end
          if (got.flash_action !== want.flash_action) begin
            $error("flash_action: expected %0d, got %0d", want.flash_action, got.flash_action);
            bad = 1'b1;
          end
          if (got.flash_address !== want.flash_address) begin
            $error("flash_address: expected %h, got %h", want.flash_address, got.flash_address);
            bad = 1'b1;
          end
          if (got.program_byte !== want.program_byte) begin
            $error("program_byte: expected %h, got %h", want.program_byte, got.program_byte);
            bad = 1'b1;
          end
          if (bad) fails++;
          if (want.flash_action == ACT_PROGRAM) n_programmed++;
          if (want.flash_action == ACT_HEADER) n_commits++;
          if (!want.accepted) n_refused++;
        end
      end
      if (in_valid && in_ready) begin
        seen = {in_func, in_slot, in_expected_crc, in_chunk_offset, in_chunk_length,
                in_data_byte};
        resp_due.push_back(judge_upload_item(seen));
        n_items++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BUNDLE_BYTES: reg_bundle = cfg_wdata[23:0];
          REG_SLOT_BYTES:   reg_slot_bytes = cfg_wdata[23:0];
          REG_SLOT_COUNT:   reg_slot_count = cfg_wdata[7:0];
          REG_PIXEL_OFFSET: reg_pix_off = cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
    end
    in_took <= rst_n && in_valid && in_ready;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles with no handshake", quiet_cycles);
      $display("[flash_slot_upload_checker_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] good_crc;
    int          mark;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_slot = '0;
    in_expected_crc = '0;
    in_chunk_offset = '0;
    in_chunk_length = '0;
    in_data_byte = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    plan_bundle = '0;
    plan_slots = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // store not configured: nothing may start
    post(FN_BEGIN, 32'd0, 32'd0);
    post(FN_ERASE, 32'd0, 32'd0);
    post(FN_CHUNK, 32'd0, 32'd1);
    post(FN_DATA, 32'h5A, 32'd0);
    post(FN_FINISH, 32'd0, 32'd0);
    post(FN_ABORT, 32'd0, 32'd0);
    post(FN_SPARE_A, 32'd0, 32'd0);
    post(FN_SPARE_B, 32'd0, 32'd0);
    drain();

    write_regs(24'd2, 24'h001000, 8'd4, 16'h0020);
    good_crc = ~crc_fold(crc_fold(CRC_INIT, 8'hA5), 8'h5A);
    post(FN_BEGIN, 32'd4, good_crc);
    post(FN_ERASE, 32'd3, 32'd0);
    post(FN_BEGIN, 32'd2, good_crc);
    post(FN_BEGIN, 32'd1, 32'd0);
    post(FN_ERASE, 32'd0, 32'd0);
    post(FN_DATA, 32'hFF, 32'd0);
    post(FN_CHUNK, 32'd1, 32'd1);
    post(FN_CHUNK, 32'd0, 32'd3);
    post(FN_CHUNK, 32'd0, 32'd2);
    post(FN_DATA, 32'hA5, 32'd0);
    // new chunk replaces what is left of the open one
    post(FN_CHUNK, 32'd1, 32'd1);
    post(FN_DATA, 32'h5A, 32'd0);
    post(FN_FINISH, 32'd0, 32'd0);
    post(FN_BEGIN, 32'd0, ~good_crc);
    post(FN_CHUNK, 32'd0, 32'd2);
    post(FN_DATA, 32'hA5, 32'd0);
    post(FN_DATA, 32'h5A, 32'd0);
    post(FN_FINISH, 32'd0, 32'd0);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_regs(24'd0, 24'd0, 8'd1, 16'd0);
        1: write_regs(24'd16, 24'h002000, 8'd8, 16'h0100);
        2: write_regs(24'd37, 24'hFFFFFF, 8'd255, 16'hFFFF);
        3: write_regs(24'hFFFFFF, 24'h010000, 8'd16, 16'h1234);
        default: write_regs(24'($urandom_range(1, 40)), 24'($urandom),
                            8'($urandom_range(1, 255)), 16'($urandom));
      endcase
      if (p == 5) idle_en = 1'b0;
      mark = queued;
      while (queued - mark < PHASE_ITEMS) begin
        queue_session();
        if ($urandom_range(0, 3) == 0) post(FN_ERASE, pick_slot(), 32'd0);
        if ($urandom_range(0, 7) == 0) enqueue(rnd_cmd());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (resp_due.size() != 0) $error("%0d results never arrived", resp_due.size());
    $display("ran %0d items under %0d register settings, %0d refused", n_items, n_settings,
             n_refused);
    $display("programmed %0d bytes and committed %0d uploads", n_programmed, n_commits);
    if (fails == 0 && resp_due.size() == 0) begin
      $display("[flash_slot_upload_checker_top] OK");
    end else begin
      $display("[flash_slot_upload_checker_top] ERROR");
    end
    $finish;
  end

endmodule

>>> flash_slot_upload_checker_top.f
hdl/fsuc_pkg.sv
hdl/fsuc_front.sv
hdl/fsuc_queue.sv
hdl/fsuc_back.sv
hdl/flash_slot_upload_checker_top.sv
sim/flash_slot_upload_checker_top_tb.sv
